@@ hw/rtl/tgpr_pkg.sv @@
// Package for the text glyph pixel renderer.
// Holds the state type, the font constants and the 5x7 glyph ROM function.
// No dependencies.
package tgpr_pkg;

  localparam int GLYPH_ROWS   = 7;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_CELLS  = GLYPH_ROWS * GLYPH_COLS;
  localparam int ADVANCE_X    = 6;
  localparam int LINE_STEP    = 9;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] HIGH_CODE    = 8'd128;
  localparam logic [7:0] STAR_CODE    = 8'h2A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] QUERY_CODE   = 8'h3F;
  localparam logic [7:0] LOWER_A      = 8'h61;
  localparam logic [7:0] LOWER_Z      = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef logic [GLYPH_CELLS-1:0] glyph_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  function automatic logic [7:0] map_code(input logic [7:0] c);
    logic [7:0] m;
    m = c;
    if (c == STAR_CODE) begin
      m = SPACE_CODE;
    end else if (c >= HIGH_CODE) begin
      m = QUERY_CODE;
    end else if (c >= LOWER_A && c <= LOWER_Z) begin
      m = c - CASE_OFFSET;
    end
    return m;
  endfunction

  // Row 0 lands in the top bits; within a row, column 0 is the row's bit 4.
  function automatic glyph_t glyph_bits(input logic [7:0] raw);
    glyph_t g;
    g = '0;
    case (map_code(raw))
      "A": g = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "B": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      "C": g = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      "D": g = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      "E": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      "F": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      "G": g = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      "H": g = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "I": g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd31};
      "J": g = {5'd1,  5'd1,  5'd1,  5'd1,  5'd17, 5'd17, 5'd14};
      "K": g = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      "L": g = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      "M": g = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      "N": g = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      "O": g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "P": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      "Q": g = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      "R": g = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      "S": g = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30};
      "T": g = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};
      "U": g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "V": g = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      "W": g = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      "X": g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17};
      "Y": g = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};
      "Z": g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31};
      "0": g = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      "1": g = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
      "2": g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
      "3": g = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
      "4": g = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
      "5": g = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
      "6": g = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      "7": g = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
      "8": g = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      "9": g = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
      ".": g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12};
      ",": g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd8};
      ":": g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};
      ";": g = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd8,  5'd0};
      "!": g = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4};
      "?": g = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd0,  5'd4};
      "-": g = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};
      "_": g = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31};
      "/": g = {5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd0,  5'd0};
      "(": g = {5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd4,  5'd2};
      ")": g = {5'd8,  5'd4,  5'd2,  5'd2,  5'd2,  5'd4,  5'd8};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

@@ hw/rtl/text_glyph_pixel_renderer.sv @@
// Top level of the text glyph pixel renderer: cursor state, glyph bit
// shifter and the registered pixel-write output.
// Depends on tgpr_pkg.
// Usage: each beat on the s_ group carries one character. s_tuser is the
// first_of_text flag, which loads the cursor and the line start from
// start_x and start_y before the character is handled. A newline (code 10)
// moves the cursor to the line start and 9 rows down and gives no beats.
// Any other character is mapped and looked up in the built-in 5x7 font;
// its glyph is loaded into a 35-bit shift register that is scanned one
// cell per cycle unless stalled, row 0 first, column 0 first. Every set
// cell gives one beat on the m_ group with the pixel coordinates and the
// ink color, and m_tlast marks the final write of the character. Blank
// glyphs give no beats; the cursor still advances by 6 columns.
// Sequence: after a character is accepted, the scan steps through the glyph
// cells up to the last set one while the input is held; a newline or a
// blank glyph starts no scan. The next character is accepted once the scan
// is done, while the last pixel beat may still wait in the output register.
// Stalls: while m_tready is low with a beat pending, the scan holds.
// Reset clears the cursor, the line start, the scan and the output valid.
module text_glyph_pixel_renderer import tgpr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // s_tdata fields, low bit up: char_code, start_x, start_y, ink_color
  input  logic [((16 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // s_tuser: first_of_text
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // m_tdata fields, low bit up: pixel_x, pixel_y, pixel_color
  output logic [((8 + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
  // m_tlast: last_pixel
  output logic                m_tlast
);

  localparam int M_W = ((8 + 2 * COORD_BITS + 7) / 8) * 8;
  localparam int COL_W = $clog2(GLYPH_COLS);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_COLS - 1);

  typedef logic [COORD_BITS-1:0] coord_t;

  // Input fields.
  logic [7:0] in_code;
  coord_t     in_x;
  coord_t     in_y;
  logic [7:0] in_color;

  assign in_code  = s_tdata[7:0];
  assign in_x     = s_tdata[8 +: COORD_BITS];
  assign in_y     = s_tdata[8 + COORD_BITS +: COORD_BITS];
  assign in_color = s_tdata[8 + 2 * COORD_BITS +: 8];

  state_t           state;
  coord_t           cursor_col;
  coord_t           cursor_row;
  coord_t           line_start_col;
  glyph_t           cells;       // remaining glyph cells, current cell on top
  logic [COL_W-1:0] col;
  coord_t           scan_x;
  coord_t           scan_y;
  coord_t           left_x;      // left edge of the glyph being scanned
  logic [7:0]       color;

  coord_t     out_x;
  coord_t     out_y;
  logic [7:0] out_color;

  logic   accept;
  logic   advance;
  logic   rest_empty;
  coord_t base_x;
  coord_t base_y;
  coord_t base_line;
  glyph_t in_glyph;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  // The scan moves on whenever the output register is free or draining.
  assign advance    = !m_tvalid || m_tready;
  assign rest_empty = (cells[GLYPH_CELLS-2:0] == '0);

  assign base_x    = s_tuser ? in_x : cursor_col;
  assign base_y    = s_tuser ? in_y : cursor_row;
  assign base_line = s_tuser ? in_x : line_start_col;
  assign in_glyph  = glyph_bits(in_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cursor_col     <= '0;
      cursor_row     <= '0;
      line_start_col <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // A set cell loads the output register; otherwise a taken beat empties it.
      if (state == ST_RUN && advance && cells[GLYPH_CELLS-1]) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            line_start_col <= base_line;
            if (in_code == NEWLINE_CODE) begin
              cursor_col <= base_line;
              cursor_row <= base_y + COORD_BITS'(LINE_STEP);
            end else begin
              cursor_col <= base_x + COORD_BITS'(ADVANCE_X);
              cursor_row <= base_y;
              if (in_glyph != '0) begin
                state <= ST_RUN;
              end
            end
          end
        end
        ST_RUN: begin
          if (advance && rest_empty) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scan datapath: one glyph cell per cycle unless stalled, coordinates stepped alongside.
  always_ff @(posedge clk) begin
    if (accept) begin
      cells  <= in_glyph;
      col    <= '0;
      scan_x <= base_x;
      scan_y <= base_y;
      left_x <= base_x;
      color  <= in_color;
    end else if (state == ST_RUN && advance) begin
      cells <= {cells[GLYPH_CELLS-2:0], 1'b0};
      if (cells[GLYPH_CELLS-1]) begin
        out_x     <= scan_x;
        out_y     <= scan_y;
        out_color <= color;
        m_tlast   <= rest_empty;
      end
      if (col == LAST_COL) begin
        col    <= '0;
        scan_x <= left_x;
        scan_y <= scan_y + COORD_BITS'(1);
      end else begin
        col    <= col + COL_W'(1);
        scan_x <= scan_x + COORD_BITS'(1);
      end
    end
  end

  assign m_tdata = M_W'({out_color, out_y, out_x});

  // A running scan always has at least one set cell left.
  a_run_has_cells: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> cells != '0)
    else $error("scan running with no set cell left");

  // The column counter stays inside the glyph width.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> col <= LAST_COL)
    else $error("glyph column out of range");

  // The final set cell ends the scan and leaves a marked beat behind.
  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && advance && cells[GLYPH_CELLS-1] && rest_empty
    |=> state == ST_IDLE && m_tvalid && m_tlast)
    else $error("last pixel did not end the scan");

  // A character is accepted only with the scan idle.
  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    $past(state == ST_RUN && !(advance && rest_empty)) |-> !s_tready)
    else $error("input ready during a scan");

endmodule

@@ tb/sv/text_glyph_pixel_renderer_tb.sv @@
// Self-checking testbench for the text glyph pixel renderer.
// Streams characters in, predicts every pixel beat in a local font model and
// checks the output stream. Depends on tgpr_pkg and text_glyph_pixel_renderer.
module text_glyph_pixel_renderer_tb import tgpr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 12;           // coordinate width used by the DUT
  localparam int SD_W = 40;         // char_code + start_x + start_y + ink_color
  localparam int MD_W = 32;         // pixel_x + pixel_y + pixel_color
  localparam int HOLD_CYCLES = 400; // long output back-pressure window
  localparam int HOLD_AFTER = 25;   // characters accepted before the hold starts
  localparam int RANDOM_CHARS = 108;
  localparam int DRAIN_CYCLES = 60;

  // One character beat as the sender sees it.
  typedef struct packed {
    logic [7:0]    code;
    logic          first;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [7:0]    ink;
  } char_beat_t;

  // One expected pixel write.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [7:0]    color;
    logic          last;
  } pixel_t;

  // Glyph rows, index 0 is the top row; bit 4 of a row is the leftmost column.
  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] font_rows_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [SD_W-1:0] s_tdata = '0;
  logic            s_tuser = 1'b0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [MD_W-1:0] m_tdata;
  logic            m_tlast;

  text_glyph_pixel_renderer #(.COORD_BITS(CW)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Characters waiting to be offered, and pixel writes the DUT still owes us.
  char_beat_t char_q[$];
  pixel_t     pixel_q[$];
  char_beat_t cur_char;

  // Local copy of the cursor state.
  logic [CW-1:0] cur_col = '0;
  logic [CW-1:0] cur_row = '0;
  logic [CW-1:0] line_col = '0;

  int n_accepted = 0;
  int n_pixels = 0;
  int n_newlines = 0;
  int n_blanks = 0;
  int n_errors = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Every mismatch goes through here: one line, one count.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // Code folding done ahead of the font lookup: '*' renders blank, any code
  // with the top bit set renders as '?', and lowercase folds to uppercase.
  function automatic logic [7:0] fold_code(input logic [7:0] raw);
    if (raw == STAR_CODE) return SPACE_CODE;
    if (raw[7]) return QUERY_CODE;
    if (raw >= "a" && raw <= "z") return raw - 8'd32;
    return raw;
  endfunction

  // 5x7 font; anything missing from the table is a blank glyph.
  function automatic font_rows_t font_lookup(input logic [7:0] ch);
    case (ch)
      "A": return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "B": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
      "C": return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
      "D": return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
      "E": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
      "F": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
      "G": return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14};
      "H": return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
      "I": return {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd31};
      "J": return {5'd1, 5'd1, 5'd1, 5'd1, 5'd17, 5'd17, 5'd14};
      "K": return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
      "L": return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
      "M": return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
      "N": return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
      "O": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "P": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
      "Q": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
      "R": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
      "S": return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
      "T": return {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
      "U": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
      "V": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
      "W": return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
      "X": return {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
      "Y": return {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
      "Z": return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
      "0": return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
      "1": return {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
      "2": return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
      "3": return {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
      "4": return {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
      "5": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
      "6": return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
      "7": return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
      "8": return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
      "9": return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
      ".": return {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
      ",": return {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd8};
      ":": return {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
      ";": return {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd8, 5'd0};
      "!": return {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4};
      "?": return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
      "-": return {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
      "_": return {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
      "/": return {5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd0, 5'd0};
      "(": return {5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2};
      ")": return {5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8};
      default: return '0;
    endcase
  endfunction

  // Advances the local cursor for one accepted character and queues the
  // pixel writes it must produce, in row-major scan order.
  task automatic render_char(input char_beat_t ch);
    font_rows_t rows;
    pixel_t     px;
    int         total;
    int         k;
    if (ch.first) begin
      cur_col  = ch.sx;
      line_col = ch.sx;
      cur_row  = ch.sy;
    end
    // A newline is applied after any origin load and writes nothing.
    if (ch.code == NEWLINE_CODE) begin
      cur_col = line_col;
      cur_row = cur_row + CW'(LINE_STEP);
      n_newlines++;
      return;
    end
    rows  = font_lookup(fold_code(ch.code));
    total = $countones(rows);
    k     = 0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      for (int c = 0; c < GLYPH_COLS; c++) begin
        if (rows[r][GLYPH_COLS-1-c]) begin
          k++;
          px.x     = cur_col + CW'(c);
          px.y     = cur_row + CW'(r);
          px.color = ch.ink;
          px.last  = (k == total);
          pixel_q.push_back(px);
        end
      end
    end
    if (total == 0) n_blanks++;
    cur_col = cur_col + CW'(ADVANCE_X);
  endtask

  // Idle and stall rates by test phase, keyed on characters accepted so far:
  // a clean stretch (with the long hold inside it), sender gaps, receiver
  // stalls, light gaps on both sides, then clean again.
  function automatic int sender_gap_pct(input int n);
    if (n >= 45 && n < 80) return 45;
    if (n >= 115 && n < 140) return 10;
    return 0;
  endfunction

  function automatic int sink_stall_pct(input int n);
    if (n >= 80 && n < 115) return 45;
    if (n >= 115 && n < 140) return 10;
    return 0;
  endfunction

  // Sender. A held beat stays put until it is taken; gaps are only inserted
  // between beats, never by dropping tvalid on an offered beat.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        render_char(cur_char);
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct(n_accepted)) begin
          cur_char = char_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_char.ink, cur_char.sy, cur_char.sx, cur_char.code};
          s_tuser  <= cur_char.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure window: once enough characters are in, the output is
  // held blocked while the sender keeps offering, so the renderer stalls its
  // scan and then its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver and checker. Each pixel beat is matched against the oldest
  // expected write, field by field.
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct(n_accepted));
      if (m_tvalid && m_tready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel beat x=%0d y=%0d",
                                    m_tdata[11:0], m_tdata[23:12]));
        end else begin
          want = pixel_q.pop_front();
          n_pixels++;
          if (m_tdata[11:0] != want.x)
            report_mismatch($sformatf("pixel_x got %0d want %0d", m_tdata[11:0], want.x));
          if (m_tdata[23:12] != want.y)
            report_mismatch($sformatf("pixel_y got %0d want %0d", m_tdata[23:12], want.y));
          if (m_tdata[31:24] != want.color)
            report_mismatch($sformatf("pixel_color got %0d want %0d",
                                      m_tdata[31:24], want.color));
          if (m_tlast != want.last)
            report_mismatch($sformatf("last_pixel got %0b want %0b at x=%0d y=%0d",
                                      m_tlast, want.last, want.x, want.y));
        end
      end
    end
  end

  task automatic queue_char(input logic [7:0] code, input logic first,
                            input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                            input logic [7:0] ink);
    char_beat_t ch;
    ch.code  = code;
    ch.first = first;
    ch.sx    = sx;
    ch.sy    = sy;
    ch.ink   = ink;
    char_q.push_back(ch);
  endtask

  // Picks a character for random text: mostly printable glyphs, with some
  // lowercase, newlines, blanks and arbitrary bytes mixed in.
  function automatic logic [7:0] pick_char();
    string punct;
    int    sel;
    punct = ".,:;!?-_/()";
    sel = $urandom_range(0, 99);
    if (sel < 40) return 8'("A" + $urandom_range(0, 25));
    if (sel < 55) return 8'("a" + $urandom_range(0, 25));
    if (sel < 68) return 8'("0" + $urandom_range(0, 9));
    if (sel < 80) return punct[$urandom_range(0, punct.len() - 1)];
    if (sel < 88) return NEWLINE_CODE;
    if (sel < 93) return ($urandom_range(0, 1) != 0) ? STAR_CODE : SPACE_CODE;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int            made;
    int            run_len;
    logic [CW-1:0] ox;
    logic [CW-1:0] oy;

    // Directed: color extremes, case folding, every blank flavor, the high
    // code range, newline combined with an origin load, and coordinate wrap.
    queue_char("A", 1'b1, 12'd0, 12'd0, 8'd0);
    queue_char("b", 1'b0, 12'd0, 12'd0, 8'd255);
    queue_char("z", 1'b0, 12'hFFF, 12'hFFF, 8'h5A);
    queue_char(STAR_CODE, 1'b0, 12'd0, 12'd0, 8'h11);
    queue_char(SPACE_CODE, 1'b0, 12'd0, 12'd0, 8'h22);
    queue_char(8'd0, 1'b0, 12'd0, 12'd0, 8'h33);
    queue_char(8'd127, 1'b0, 12'd0, 12'd0, 8'h44);
    queue_char(8'd128, 1'b0, 12'd0, 12'd0, 8'h80);
    queue_char(8'd255, 1'b0, 12'd0, 12'd0, 8'hFF);
    queue_char(NEWLINE_CODE, 1'b1, 12'hFFF, 12'hFFF, 8'h01);
    queue_char("M", 1'b0, 12'd0, 12'd0, 8'h02);
    queue_char("W", 1'b1, 12'd4093, 12'd4093, 8'h03);
    queue_char(NEWLINE_CODE, 1'b0, 12'd0, 12'd0, 8'h04);
    queue_char("0", 1'b0, 12'd0, 12'd0, 8'h05);
    queue_char("9", 1'b0, 12'd0, 12'd0, 8'h06);
    queue_char("_", 1'b1, 12'd100, 12'd200, 8'h07);
    queue_char("(", 1'b0, 12'd0, 12'd0, 8'h08);
    queue_char(")", 1'b0, 12'd0, 12'd0, 8'h09);
    queue_char("/", 1'b0, 12'd0, 12'd0, 8'h0A);
    queue_char("?", 1'b0, 12'd0, 12'd0, 8'h0B);
    queue_char("8", 1'b1, 12'h800, 12'h7FF, 8'hAA);

    // Random: runs of text, each opened by an origin load. The origin fields
    // of other beats carry junk, which the DUT must ignore.
    made = 0;
    while (made < RANDOM_CHARS) begin
      if ($urandom_range(0, 7) == 0) begin
        ox = 12'(4080 + $urandom_range(0, 15));
        oy = 12'(4080 + $urandom_range(0, 15));
      end else begin
        ox = 12'($urandom_range(0, 4095));
        oy = 12'($urandom_range(0, 4095));
      end
      queue_char(pick_char(), 1'b1, ox, oy, 8'($urandom_range(0, 255)));
      made++;
      run_len = $urandom_range(3, 12);
      for (int i = 0; i < run_len; i++) begin
        queue_char(pick_char(), 1'b0, 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
        made++;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for the sender to drain, then for every owed pixel to arrive.
    @(negedge clk);
    while (char_q.size() != 0 || s_tvalid) @(negedge clk);
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Rendered %0d characters (%0d newlines, %0d blank glyphs); %0d pixel beats checked.",
             n_accepted, n_newlines, n_blanks, n_pixels);
    if (n_errors == 0) begin
      $display("text_glyph_pixel_renderer_tb: done, clean");
    end else begin
      $display("text_glyph_pixel_renderer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d pixel writes outstanding.", pixel_q.size());
    $display("text_glyph_pixel_renderer_tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tgpr_pkg.sv
hw/rtl/text_glyph_pixel_renderer.sv
tb/sv/text_glyph_pixel_renderer_tb.sv
